// ===== sv/spt_pkg.sv =====
package spt_pkg;

    // Sampled PWM counter width; counter values are masked to this when narrower than 16.
    localparam int COUNT_WIDTH = 16;
    localparam logic [15:0] CNT_MASK = (COUNT_WIDTH >= 16) ? 16'hFFFF
                                     : 16'((32'd1 << COUNT_WIDTH) - 32'd1);

    // Divider: magnitude of a clamped error and the divisor are both 15 bits.
    localparam int DIV_BITS = 15;
    localparam int STEP_CNT_W = $clog2(DIV_BITS);

    // Register indexes on the config port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_PHASE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADJUST_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE    = 3'd4;

    // Reset values of the config registers
    localparam logic [15:0] RST_DEFAULT_PERIOD = 16'd12500;
    localparam logic [15:0] RST_REF_PHASE      = 16'd3125;
    localparam logic [14:0] RST_ADJUST_MAX     = 15'd300;
    localparam logic [14:0] RST_ADJUST_COUNT   = 15'd1;
    localparam logic        RST_SYNC_ENABLE    = 1'b1;

    // Item opcodes
    localparam logic OP_SYNC = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] phase_count;
    } spt_item_t;

    typedef struct packed {
        logic               kind;
        logic [15:0]        period_value;
        logic signed [15:0] phase_error;
        logic               locked;
        logic [15:0]        miss_count;
    } spt_result_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;    // latch accepted item, form raw phase error
        logic div_start;  // clamp error, load divider
        logic div_step;   // one restoring-division bit
        logic commit;     // update state, load result register
    } spt_cmd_t;

endpackage

// ===== sv/spt_ctrl.sv =====
module spt_ctrl
    import spt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_opcode,
    output logic     item_stall,
    output logic     result_valid,
    input  logic     result_stall,
    output spt_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] step_cnt_reg, step_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  out_free;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_cnt_next  = step_cnt_reg;
        out_valid_next = out_valid_reg && result_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (item_opcode == OP_SYNC) ? ST_START : ST_FIN;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_CNT_W'(DIV_BITS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_cnt_reg  <= step_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register is only overwritten once its word has gone
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !result_stall))
        else $error("commit while result word still stalled");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("commit did not raise result_valid");

    a_sync_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_opcode == OP_SYNC) |=> (state_reg == ST_START))
        else $error("sync word did not start the divider");

    a_tick_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item_opcode == OP_TICK) |=> (state_reg == ST_FIN))
        else $error("tick word took the divider path");

endmodule

// ===== sv/spt_dp.sv =====
module spt_dp
    import spt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  spt_item_t            item,
    input  spt_cmd_t             cmd,
    output spt_result_t          result
);

    // config
    logic [15:0] default_period_reg;
    logic [15:0] ref_phase_reg;
    logic [14:0] adjust_max_reg;
    logic [14:0] adjust_count_reg;
    logic        sync_enable_reg;

    // persistent state
    logic [15:0] step_offset_reg, step_offset_next;
    logic [15:0] dither_left_reg, dither_left_next;
    logic [15:0] last_error_reg, last_error_next;
    logic        lock_flag_reg, lock_flag_next;
    logic [15:0] miss_cnt_reg, miss_cnt_next;

    // per-item working registers
    logic        op_reg;
    logic [15:0] err_reg;
    logic        in_range_reg;
    logic        neg_reg;
    logic [14:0] quot_reg;
    logic [14:0] rem_reg;
    logic [14:0] div_reg;
    spt_result_t result_reg;

    // clamp
    logic signed [15:0] err_s, lim_s, neg_lim_s, clamp_s;
    logic               in_range;
    logic [15:0]        clamp_abs;

    // divider step
    logic [15:0] rem_shift;
    logic        ge;

    // commit
    logic [15:0] q_ext, r_ext, q_signed, r_signed;
    logic [15:0] base_period, period;

    assign err_s     = signed'(err_reg);
    assign lim_s     = signed'({1'b0, adjust_max_reg});
    assign neg_lim_s = 16'sd0 - lim_s;
    assign in_range  = (err_s <= lim_s) && (err_s >= neg_lim_s);
    assign clamp_s   = in_range ? err_s : ((err_s > lim_s) ? lim_s : neg_lim_s);
    assign clamp_abs = clamp_s[15] ? (16'd0 - 16'(clamp_s)) : 16'(clamp_s);

    assign rem_shift = {rem_reg, quot_reg[DIV_BITS-1]};
    assign ge        = (rem_shift >= {1'b0, div_reg});

    assign q_ext    = {1'b0, quot_reg};
    assign r_ext    = {1'b0, rem_reg};
    assign q_signed = neg_reg ? (16'd0 - q_ext) : q_ext;
    assign r_signed = neg_reg ? (16'd0 - r_ext) : r_ext;

    always_comb
    begin
        step_offset_next = step_offset_reg;
        dither_left_next = dither_left_reg;
        last_error_next  = last_error_reg;
        lock_flag_next   = lock_flag_reg;
        miss_cnt_next    = miss_cnt_reg;
        base_period      = default_period_reg + step_offset_reg;
        period           = base_period;
        if (op_reg == OP_SYNC)
        begin
            step_offset_next = q_signed;
            dither_left_next = r_signed;
            last_error_next  = err_reg;
            lock_flag_next   = lock_flag_reg || (in_range_reg && sync_enable_reg);
            miss_cnt_next    = miss_cnt_reg + {15'd0, !in_range_reg};
            period           = default_period_reg + q_signed;
        end
        else if (dither_left_reg[15])
        begin
            period           = base_period - 16'd1;
            dither_left_next = dither_left_reg + 16'd1;
        end
        else if (dither_left_reg != 16'd0)
        begin
            period           = base_period + 16'd1;
            dither_left_next = dither_left_reg - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_period_reg <= RST_DEFAULT_PERIOD;
            ref_phase_reg      <= RST_REF_PHASE;
            adjust_max_reg     <= RST_ADJUST_MAX;
            adjust_count_reg   <= RST_ADJUST_COUNT;
            sync_enable_reg    <= RST_SYNC_ENABLE;
            step_offset_reg    <= '0;
            dither_left_reg    <= '0;
            last_error_reg     <= '0;
            lock_flag_reg      <= 1'b0;
            miss_cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DEFAULT_PERIOD: default_period_reg <= cfg_data;
                    REG_REF_PHASE:      ref_phase_reg      <= cfg_data;
                    REG_ADJUST_MAX:     adjust_max_reg     <= cfg_data[14:0];
                    REG_ADJUST_COUNT:   adjust_count_reg   <= cfg_data[14:0];
                    REG_SYNC_ENABLE:    sync_enable_reg    <= cfg_data[0];
                    default:            ;
                endcase
            end
            if (cmd.commit)
            begin
                step_offset_reg <= step_offset_next;
                dither_left_reg <= dither_left_next;
                last_error_reg  <= last_error_next;
                lock_flag_reg   <= lock_flag_next;
                miss_cnt_reg    <= miss_cnt_next;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= item.opcode;
            err_reg <= (item.phase_count & CNT_MASK) - ref_phase_reg;
        end
        if (cmd.div_start)
        begin
            in_range_reg <= in_range;
            neg_reg      <= clamp_s[15];
            quot_reg     <= clamp_abs[14:0];
            rem_reg      <= '0;
            div_reg      <= (adjust_count_reg == 15'd0) ? 15'd1 : adjust_count_reg;
        end
        if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[DIV_BITS-2:0], ge};
            rem_reg  <= ge ? 15'(rem_shift - {1'b0, div_reg}) : rem_shift[14:0];
        end
        if (cmd.commit)
        begin
            result_reg.kind         <= op_reg;
            result_reg.period_value <= period & CNT_MASK;
            result_reg.phase_error  <= signed'(last_error_next);
            result_reg.locked       <= lock_flag_next;
            result_reg.miss_count   <= miss_cnt_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== sv/sync_pwm_period_trim.sv =====
// PWM period trim for phase lock to a bus sync event. Two kinds of input word:
// a sync word (opcode 0) carries the PWM counter sampled at the sync event; the
// phase error (counter - ref_phase, wrapped to signed 16 bits) is clamped to
// +/-adjust_max and divided by adjust_count (0 acts as 1), truncating toward
// zero. Quotient becomes the per-period offset, remainder a dither count. An
// in-range error sets the sticky locked flag when sync_enable is 1; an
// out-of-range one bumps miss_count. A tick word (opcode 1) returns
// default_period + offset, +/-1 while dither is nonzero, and steps dither
// toward zero. Every input word produces exactly one result word. A sync
// word passes through capture, clamp/setup, 15 restoring-division steps at
// one quotient bit per cycle and commit; a tick word goes from capture
// straight to commit. The result sits in an output register, so the next
// input word is taken while the previous result still waits on
// result_stall. Config writes are always ready (cfg_ready tied high) and
// should be issued only while the block is idle.
module sync_pwm_period_trim
    import spt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 item_valid,
    output logic                 item_stall,
    input  spt_item_t            item,
    // result words
    output logic                 result_valid,
    input  logic                 result_stall,
    output spt_result_t          result,
    // config register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    spt_cmd_t cmd;
    logic     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // sequencing: idle / setup / divide / commit
    spt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_opcode  (item.opcode),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd)
    );

    // config registers, trim state, serial divider, result register
    spt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .result    (result)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Bench for the PWM period trim block.
// Input and result words both use a valid/stall handshake; config writes use
// valid/ready. A local model of the trim logic predicts one result word per
// accepted input word. The monitor compares each accepted result with the
// oldest prediction, field by field.
module tb;
    import spt_pkg::*;

    localparam int SETTLE_CYCLES = 24;    // idle margin after the last prediction drains
    localparam int HOLD_CYCLES   = 400;   // long result back-pressure stretch
    localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
    localparam int NUM_PHASES    = 8;
    localparam int WORDS_PER_PHASE = 140;
    localparam int QUIET_PHASE    = 2;    // no idling on either side
    localparam int PRESSURE_PHASE = 5;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    spt_item_t            item;
    logic                 result_valid;
    logic                 result_stall;
    spt_result_t          result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    sync_pwm_period_trim dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Trim model: config copy and state
    // ------------------------------------------------------------------
    logic [15:0]        nom_period;
    logic [15:0]        target_phase;
    logic [14:0]        err_limit;
    logic [14:0]        spread_count;
    logic               lock_en;
    logic signed [15:0] offset_q;
    logic signed [15:0] dither_q;
    logic signed [15:0] meas_err;
    logic               lock_q;
    logic [15:0]        miss_q;

    spt_result_t results_due[$];   // predicted result words, oldest first
    int          mismatches;
    bit          quiet;            // suppress random idling on both sides
    bit          hold_req;         // ask the receiver for one long hold-off

    function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            REG_DEFAULT_PERIOD: nom_period   = data;
            REG_REF_PHASE:      target_phase = data;
            REG_ADJUST_MAX:     err_limit    = data[14:0];
            REG_ADJUST_COUNT:   spread_count = data[14:0];
            REG_SYNC_ENABLE:    lock_en      = data[0];
            default: ;
        endcase
    endfunction

    // Advance the model by one input word and return the word it predicts.
    function automatic spt_result_t trim_step(spt_item_t w);
        logic [15:0]        cnt;
        logic signed [15:0] diff;
        logic [15:0]        per;
        int                 err, lim, div, e, d;
        spt_result_t        r;
        if (w.opcode == OP_SYNC)
        begin
            cnt  = w.phase_count & CNT_MASK;
            diff = cnt - target_phase;          // wraps to signed 16 bits
            err  = diff;
            lim  = err_limit;
            div  = (spread_count == 0) ? 1 : int'(spread_count);
            meas_err = diff;
            if (err <= lim && err >= -lim)
            begin
                e = err;
                if (lock_en)
                    lock_q = 1'b1;              // sticky until reset
            end
            else
            begin
                e      = (err > lim) ? lim : -lim;
                miss_q = miss_q + 16'd1;
            end
            offset_q = 16'(e / div);            // truncates toward zero
            dither_q = 16'(e % div);
            per      = nom_period + offset_q;
        end
        else
        begin
            d   = dither_q;
            per = nom_period + offset_q;
            if (d > 0)
            begin
                per = per + 16'd1;
                d   = d - 1;
            end
            else if (d < 0)
            begin
                per = per - 16'd1;
                d   = d + 1;
            end
            dither_q = 16'(d);
        end
        r.kind         = w.opcode;
        r.period_value = per & CNT_MASK;
        r.phase_error  = meas_err;
        r.locked       = lock_q;
        r.miss_count   = miss_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver side: random stall, one long hold-off, and the checker
    // ------------------------------------------------------------------
    int hold_left;
    bit hold_done;

    task automatic check_word(spt_result_t got);
        spt_result_t want;
        if (results_due.size() == 0)
        begin
            $error("result word with nothing pending: %p", got);
            mismatches++;
            return;
        end
        want = results_due.pop_front();
        if (got.kind !== want.kind)
        begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
        end
        if (got.period_value !== want.period_value)
        begin
            $error("period_value: expected %0d, actual %0d",
                   want.period_value, got.period_value);
            mismatches++;
        end
        if (got.phase_error !== want.phase_error)
        begin
            $error("phase_error: expected %0d, actual %0d",
                   want.phase_error, got.phase_error);
            mismatches++;
        end
        if (got.locked !== want.locked)
        begin
            $error("locked: expected %0d, actual %0d", want.locked, got.locked);
            mismatches++;
        end
        if (got.miss_count !== want.miss_count)
        begin
            $error("miss_count: expected %0d, actual %0d",
                   want.miss_count, got.miss_count);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    = 0;
            hold_done    = 1'b0;
        end
        else
        begin
            // sample the handshake with pre-edge values
            if (result_valid && !result_stall)
                check_word(result);

            if (hold_left != 0)
            begin
                hold_left    = hold_left - 1;
                result_stall <= 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done    = 1'b1;
                hold_left    = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(0, 99) < 10);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on any channel
    // ------------------------------------------------------------------
    int dead_cycles;

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
            dead_cycles = 0;
        else
            dead_cycles = dead_cycles + 1;
        if (dead_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one word, wait until it is taken, then queue its prediction.
    // Known rows queue the hand-written word; the model still advances.
    task automatic send_word(spt_item_t w, bit known, spt_result_t lit);
        spt_result_t pred;
        while (!quiet && $urandom_range(0, 99) < 10)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pred = trim_step(w);
        results_due.push_back(known ? lit : pred);
    endtask

    // cfg_valid stays high across back-to-back writes; caller lowers it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        set_reg(idx, data);
    endtask

    // Stop offering words, drain every prediction, let the datapath go quiet.
    task automatic settle();
        item_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sampled counter for a sync word: mostly near the target phase, some on
    // the clamp edges, the rest anywhere.
    function automatic logic [15:0] pick_count();
        int lim, sel, off;
        lim = err_limit;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            off = int'($urandom_range(0, 2 * lim + 6)) - (lim + 3);
        else if (sel < 7)
        begin
            case ($urandom_range(0, 3))
                0: off = lim;
                1: off = -lim;
                2: off = lim + 1;
                default: off = -lim - 1;
            endcase
        end
        else
            return 16'($urandom);
        return 16'(int'(target_phase) + off);
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
        spt_item_t            word;
        bit                   known;
        spt_result_t          lit;
    } plan_row_t;

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        plan_row_t r;
        r        = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic plan_row_t word_row(logic op, logic [15:0] cnt);
        plan_row_t r;
        r                  = '{default: '0};
        r.word.opcode      = op;
        r.word.phase_count = cnt;
        return r;
    endfunction

    function automatic plan_row_t known_row(logic op, logic [15:0] cnt, logic [15:0] per,
                                            int err, logic lock, logic [15:0] miss);
        plan_row_t r;
        r       = word_row(op, cnt);
        r.known = 1'b1;
        r.lit   = '{kind: op, period_value: per, phase_error: 16'(err),
                    locked: lock, miss_count: miss};
        return r;
    endfunction

    plan_row_t plan[$];

    initial
    begin
        plan_row_t   row;
        spt_item_t   w;
        spt_result_t none;
        bit          in_cfg;
        int          sent, ticks;
        logic [15:0] v;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        dead_cycles  = 0;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        none         = '0;
        in_cfg       = 1'b0;

        // model matches the block's reset
        nom_period   = RST_DEFAULT_PERIOD;
        target_phase = RST_REF_PHASE;
        err_limit    = RST_ADJUST_MAX;
        spread_count = RST_ADJUST_COUNT;
        lock_en      = RST_SYNC_ENABLE;
        offset_q     = '0;
        dither_q     = '0;
        meas_err     = '0;
        lock_q       = 1'b0;
        miss_q       = '0;

        // Reset values: period 12500, ref 3125, limit 300, count 1, enabled.
        plan.push_back(known_row(OP_TICK, 16'h0000, 16'd12500, 0, 1'b0, 16'd0));
        // in range but sync disabled: no lock
        plan.push_back(cfg_row(REG_SYNC_ENABLE, 16'd0));
        plan.push_back(known_row(OP_SYNC, 16'd3125, 16'd12500, 0, 1'b0, 16'd0));
        plan.push_back(cfg_row(REG_SYNC_ENABLE, 16'd1));
        plan.push_back(known_row(OP_SYNC, 16'd3125, 16'd12500, 0, 1'b1, 16'd0));
        // clamp edges, +/-limit in range, one beyond out of range
        plan.push_back(known_row(OP_SYNC, 16'd3425, 16'd12800, 300, 1'b1, 16'd0));
        plan.push_back(known_row(OP_SYNC, 16'd3426, 16'd12800, 301, 1'b1, 16'd1));
        plan.push_back(known_row(OP_SYNC, 16'd2825, 16'd12200, -300, 1'b1, 16'd1));
        plan.push_back(known_row(OP_SYNC, 16'd2824, 16'd12200, -301, 1'b1, 16'd2));
        // counter extremes, and the error wrap at -32768 / +32767
        plan.push_back(known_row(OP_SYNC, 16'd0, 16'd12200, -3125, 1'b1, 16'd3));
        plan.push_back(known_row(OP_SYNC, 16'hFFFF, 16'd12200, -3126, 1'b1, 16'd4));
        plan.push_back(known_row(OP_SYNC, 16'd35893, 16'd12200, -32768, 1'b1, 16'd5));
        plan.push_back(known_row(OP_SYNC, 16'd35892, 16'd12800, 32767, 1'b1, 16'd6));
        plan.push_back(word_row(OP_TICK, 16'hFFFF));
        // spread over 7 periods: positive and negative dither
        plan.push_back(cfg_row(REG_ADJUST_MAX, 16'd100));
        plan.push_back(cfg_row(REG_ADJUST_COUNT, 16'd7));
        plan.push_back(word_row(OP_SYNC, 16'd3225));
        plan.push_back(word_row(OP_TICK, 16'h5555));
        plan.push_back(word_row(OP_TICK, 16'hAAAA));
        plan.push_back(word_row(OP_SYNC, 16'd3025));
        plan.push_back(word_row(OP_TICK, 16'h0000));
        plan.push_back(word_row(OP_TICK, 16'h1234));
        // zero count acts as one, zero limit, full period, lock stays set
        plan.push_back(cfg_row(REG_ADJUST_COUNT, 16'd0));
        plan.push_back(cfg_row(REG_ADJUST_MAX, 16'd0));
        plan.push_back(cfg_row(REG_SYNC_ENABLE, 16'd0));
        plan.push_back(cfg_row(REG_DEFAULT_PERIOD, 16'hFFFF));
        plan.push_back(cfg_row(REG_REF_PHASE, 16'd0));
        plan.push_back(word_row(OP_SYNC, 16'd0));
        plan.push_back(word_row(OP_SYNC, 16'd1));
        plan.push_back(word_row(OP_TICK, 16'd0));
        // widest limit and count (bit 15 of the data is dropped), period 1
        plan.push_back(cfg_row(REG_ADJUST_MAX, 16'hFFFF));
        plan.push_back(cfg_row(REG_ADJUST_COUNT, 16'hFFFF));
        plan.push_back(cfg_row(REG_DEFAULT_PERIOD, 16'd1));
        plan.push_back(word_row(OP_SYNC, 16'hFFFF));
        plan.push_back(word_row(OP_TICK, 16'hFFFF));
        plan.push_back(word_row(OP_SYNC, 16'd32767));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_cfg)
            begin
                if (!in_cfg)
                    settle();
                write_reg(row.idx, row.data);
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg)
                    cfg_valid <= 1'b0;
                in_cfg = 1'b0;
                send_word(row.word, row.known, row.lit);
            end
        end

        // Random phases, each with its own register setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            quiet = (p == QUIET_PHASE);

            case (p)
                0: v = 16'd1;
                1: v = 16'hFFFF;
                default: v = 16'($urandom_range(1, 65535));
            endcase
            write_reg(REG_DEFAULT_PERIOD, v);

            case (p)
                2: v = 16'd0;
                3: v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            write_reg(REG_REF_PHASE, v);

            case (p)
                1: v = 16'hFFFF;
                2: v = 16'd0;
                6: v = 16'($urandom);
                default: v = 16'($urandom_range(1, 2000));
            endcase
            write_reg(REG_ADJUST_MAX, v);

            case (p)
                1: v = 16'h7FFF;
                3: v = 16'h8000;    // masks to zero, acts as one
                4: v = 16'd1;
                7: v = 16'($urandom);
                default: v = 16'($urandom_range(2, 40));
            endcase
            write_reg(REG_ADJUST_COUNT, v);

            write_reg(REG_SYNC_ENABLE, 16'(p % 2));
            cfg_valid <= 1'b0;

            if (p == PRESSURE_PHASE)
                hold_req = 1'b1;

            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // sync word followed by a run of ticks that spends the dither
                    w.opcode      = OP_SYNC;
                    w.phase_count = pick_count();
                    send_word(w, 1'b0, none);
                    sent++;
                    ticks = $urandom_range(0, 6);
                    for (int t = 0; t < ticks; t++)
                    begin
                        w.opcode      = OP_TICK;
                        w.phase_count = 16'($urandom);
                        send_word(w, 1'b0, none);
                        sent++;
                    end
                end
                else
                begin
                    w = spt_item_t'(17'($urandom));
                    send_word(w, 1'b0, none);
                    sent++;
                end
            end
        end

        quiet = 1'b0;
        settle();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
